@@ rtl/dq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes of the deque
// Command and status codes, field widths and the result request that the
// control logic hands to the output register.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int ACT_W         = 3;
    localparam int STAT_W        = 3;
    localparam int OCC_W         = 5;

    // command codes
    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LIST       = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE       = 3'd0;
    localparam logic [STAT_W-1:0] ST_POP_EMPTY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_PUSH_FULL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_LISTED     = 3'd3;
    localparam logic [STAT_W-1:0] ST_LIST_EMPTY = 3'd4;

    typedef logic signed [DATA_W-1:0] t_data;

    // request to load the output register
    typedef struct packed {
        logic                valid;
        logic [STAT_W-1:0]   status;
        logic                from_mem;   // value comes from the read port
        logic                last;
        logic [OCC_W-1:0]    occupancy;
    } t_res_req;

endpackage

@@ rtl/dq_cmd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cmd_if: command channel
// Valid/ready channel that carries one deque command per transfer.
// ----------------------------------------------------------------------------
interface dq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [dq_pkg::ACT_W-1:0]            action;
    logic signed [dq_pkg::DATA_W-1:0]    item_value;

    modport source (output valid, output action, output item_value, input ready);
    modport sink   (input valid, input action, input item_value, output ready);
endinterface

@@ rtl/dq_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_res_if: result channel
// Valid/ready channel that carries one deque result per transfer.
// ----------------------------------------------------------------------------
interface dq_res_if;
    logic                                valid;
    logic                                ready;
    logic [dq_pkg::STAT_W-1:0]           status;
    logic signed [dq_pkg::DATA_W-1:0]    result_value;
    logic                                last_of_run;
    logic [dq_pkg::OCC_W-1:0]            occupancy;

    modport source (output valid, output status, output result_value,
                    output last_of_run, output occupancy, input ready);
    modport sink   (input valid, input status, input result_value,
                    input last_of_run, input occupancy, output ready);
endinterface

@@ rtl/dq_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_store: element memory
// One write port and one read port with registered read data; the read data
// holds until the next read.
// ----------------------------------------------------------------------------
module dq_store #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [IDX_W-1:0]     i_wr_addr,
    input  dq_pkg::t_data        i_wr_data,
    input  logic                 i_rd_en,
    input  logic [IDX_W-1:0]     i_rd_addr,
    output dq_pkg::t_data        o_rd_data
);
    import dq_pkg::*;

    t_data mem [DEPTH];
    t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/dq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl: deque sequencer
// Holds front index and count, drives the memory ports and walks the ring
// for pops and listings.
// ----------------------------------------------------------------------------
module dq_ctrl #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  logic [dq_pkg::ACT_W-1:0]   i_action,
    input  dq_pkg::t_data              i_item_value,
    output logic                       o_cmd_ready,
    input  logic                       i_out_free,
    output logic                       o_wr_en,
    output logic [IDX_W-1:0]           o_wr_addr,
    output dq_pkg::t_data              o_wr_data,
    output logic                       o_rd_en,
    output logic [IDX_W-1:0]           o_rd_addr,
    output dq_pkg::t_res_req           o_req
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [IDX_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_list_k, n_list_k;

    logic              full;
    logic              empty;
    logic              accept;
    logic              req_valid;
    logic [STAT_W-1:0] req_status;
    logic              req_from_mem;
    logic              req_last;

    // ring position of base + off, both below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (s >= (CNT_W+1)'(DEPTH)) begin
            s = s - (CNT_W+1)'(DEPTH);
        end
        return IDX_W'(s);
    endfunction

    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);
    assign o_cmd_ready = (r_state == S_IDLE) && i_out_free;
    assign accept      = i_cmd_valid && o_cmd_ready;
    assign o_wr_data   = i_item_value;

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_list_k     = r_list_k;
        o_wr_en      = 1'b0;
        o_wr_addr    = r_front;
        o_rd_en      = 1'b0;
        o_rd_addr    = r_front;
        req_valid    = 1'b0;
        req_status   = ST_DONE;
        req_from_mem = 1'b0;
        req_last     = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_action)
                        ACT_PUSH_FRONT: begin
                            req_valid = 1'b1;
                            if (full) begin
                                req_status = ST_PUSH_FULL;
                            end else begin
                                n_front   = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                            : r_front - 1'b1;
                                o_wr_en   = 1'b1;
                                o_wr_addr = n_front;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        ACT_PUSH_BACK: begin
                            req_valid = 1'b1;
                            if (full) begin
                                req_status = ST_PUSH_FULL;
                            end else begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = ring_add(r_front, r_count);
                                n_count   = r_count + 1'b1;
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (empty) begin
                                req_valid  = 1'b1;
                                req_status = ST_POP_EMPTY;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = r_front;
                                n_front   = ring_add(r_front, CNT_W'(1));
                                n_count   = r_count - 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        ACT_POP_BACK: begin
                            if (empty) begin
                                req_valid  = 1'b1;
                                req_status = ST_POP_EMPTY;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = ring_add(r_front, r_count - 1'b1);
                                n_count   = r_count - 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        ACT_LIST: begin
                            if (empty) begin
                                req_valid  = 1'b1;
                                req_status = ST_LIST_EMPTY;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = r_front;
                                n_list_k  = CNT_W'(1);
                                n_state   = S_LIST;
                            end
                        end
                        default: begin
                            req_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (i_out_free) begin
                    req_valid    = 1'b1;
                    req_from_mem = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LIST: begin
                // hand over the element just read, fetch the next one
                if (i_out_free) begin
                    req_valid    = 1'b1;
                    req_status   = ST_LISTED;
                    req_from_mem = 1'b1;
                    req_last     = (r_list_k == r_count);
                    if (req_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = ring_add(r_front, r_list_k);
                        n_list_k  = r_list_k + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req.valid     = req_valid;
        o_req.status    = req_status;
        o_req.from_mem  = req_from_mem;
        o_req.last      = req_last;
        o_req.occupancy = OCC_W'(32'(n_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= '0;
            r_count  <= '0;
            r_list_k <= '0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_count  <= n_count;
            r_list_k <= n_list_k;
        end
    end

endmodule

@@ rtl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Ring store of DEPTH entries with push/pop at both ends and a front-to-back
// listing.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per transfer (action, item_value). o_res
//   returns one result per push or pop, and one result per held element for
//   a listing (a single "list empty" result when nothing is held), with
//   last_of_run set on the final result of each command.
//   A push, a failed pop, an empty listing or an unused code loads the
//   output register at the accepting edge, so the result shows in the next
//   cycle and a new command can follow every cycle while the output register
//   is free. A pop reads the element memory first and then loads the output
//   register. A listing reads its elements front to back through the single
//   read port of the element memory, one element per cycle while the output
//   register is free. Intake is held while a pop or listing is in progress.
//   Reset empties the queue (count and front index cleared, output invalid);
//   memory contents are not cleared.
//   When the receiver stalls, the result holds in the output register; a
//   further command is taken only once that register is free or being
//   drained in the same cycle, and a listing pauses in place.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dq_cmd_if.sink     i_cmd,
    dq_res_if.source   o_res
);
    import dq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    logic              out_free;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_data             wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    t_data             rd_data;
    t_res_req          req;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    t_data             r_value;
    logic              r_last;
    logic [OCC_W-1:0]  r_occupancy;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (i_cmd.valid),
        .i_action     (i_cmd.action),
        .i_item_value (i_cmd.item_value),
        .o_cmd_ready  (i_cmd.ready),
        .i_out_free   (out_free),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .o_req        (req)
    );

    dq_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // output register is free when empty or its transfer completes now
    assign out_free = !r_out_valid || o_res.ready;

    // hold valid across stalls; drop it after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (req.valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload: popped or listed values come from the read port, else zero
    always_ff @(posedge i_clk) begin
        if (req.valid) begin
            r_status    <= req.status;
            r_value     <= req.from_mem ? rd_data : '0;
            r_last      <= req.last;
            r_occupancy <= req.occupancy;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_status;
    assign o_res.result_value = r_value;
    assign o_res.last_of_run  = r_last;
    assign o_res.occupancy    = r_occupancy;

endmodule

@@ tb/tb_double_ended_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue: self-checking bench for the bounded deque
// Drives push, pop, listing and unused commands through the command channel.
// A shadow ring store predicts every result. Each result transfer is compared
// field by field with the oldest prediction. A short table of directed
// commands comes first: empty and full corners, field extremes and wrap of
// the front index. Random fill and drain stretches follow. Both channels
// idle in random bursts.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH    = DEPTH_DEFAULT;
    localparam int N_RANDOM = 145;
    localparam int DUE_SIZE = 64;

    // codes the block must ignore
    localparam logic [ACT_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_UNUSED_HI = 3'd7;

    localparam t_data V_ZERO = 32'sd0;
    localparam t_data V_ONES = -32'sd1;
    localparam t_data V_MAX  = 32'sh7fff_ffff;
    localparam t_data V_MIN  = 32'sh8000_0000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_data             value;
        logic              last;
        logic [OCC_W-1:0]  occ;
    } t_dq_result;

    // one directed command, repeated reps times; rnd replaces the value with
    // a random one; typed rows carry their single result inline
    typedef struct packed {
        logic [ACT_W-1:0] act;
        t_data            value;
        logic             rnd;
        logic [4:0]       reps;
        logic             typed;
        t_dq_result       res;
    } t_dir_row;

    localparam int N_ROWS = 18;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dq_cmd_if cmd_if ();
    dq_res_if res_if ();

    double_ended_queue #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // shadow copy of the deque and the results it still owes
    t_data       shadow_store [DEPTH];
    int unsigned shadow_front = 0;
    int unsigned shadow_count = 0;
    t_dq_result  due_buf [DUE_SIZE];
    int unsigned due_wr = 0;
    int unsigned due_rd = 0;

    // typed result that travels on the bus with the current command
    logic        row_typed;
    t_dq_result  row_result;

    bit          gaps_on;
    int          stall_left = 0;
    int          errors     = 0;
    int          n_cmds     = 0;
    int          n_checked  = 0;
    int          n_lists    = 0;
    int          n_full     = 0;
    int          n_empty    = 0;

    t_dir_row    dir_rows [N_ROWS];

    // Append one owed result.
    function automatic void due_put(input t_dq_result r);
        due_buf[due_wr % DUE_SIZE] = r;
        due_wr++;
    endfunction

    // Number of results still owed.
    function automatic int unsigned due_level();
        return due_wr - due_rd;
    endfunction

    // Apply one accepted command to the shadow deque and queue what the
    // block must return for it.
    function automatic void deque_apply(input logic [ACT_W-1:0] act, input t_data val);
        t_dq_result  r;
        int unsigned k;
        r = '{status: ST_DONE, value: V_ZERO, last: 1'b1, occ: '0};
        case (act)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_PUSH_FULL;
                    n_full++;
                end else begin
                    if (act == ACT_PUSH_FRONT) begin
                        shadow_front = (shadow_front == 0) ? DEPTH - 1 : shadow_front - 1;
                        shadow_store[shadow_front] = val;
                    end else begin
                        shadow_store[(shadow_front + shadow_count) % DEPTH] = val;
                    end
                    shadow_count++;
                end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
                if (shadow_count == 0) begin
                    r.status = ST_POP_EMPTY;
                    n_empty++;
                end else begin
                    if (act == ACT_POP_FRONT) begin
                        r.value      = shadow_store[shadow_front];
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end else begin
                        r.value = shadow_store[(shadow_front + shadow_count - 1) % DEPTH];
                    end
                    shadow_count--;
                end
            end
            ACT_LIST: begin
                n_lists++;
                if (shadow_count == 0) begin
                    r.status = ST_LIST_EMPTY;
                end else begin
                    // walk front to back, mark the final element
                    for (k = 0; k < shadow_count; k++) begin
                        r.status = ST_LISTED;
                        r.value  = shadow_store[(shadow_front + k) % DEPTH];
                        r.last   = (k + 1 == shadow_count);
                        r.occ    = OCC_W'(shadow_count);
                        due_put(r);
                    end
                    return;
                end
            end
            default: begin
                // unused codes: plain done, nothing changes
            end
        endcase
        r.occ = OCC_W'(shadow_count);
        due_put(r);
    endfunction

    // Present one command, after an optional idle burst, and hold it until
    // the transfer happens.
    task automatic send_cmd(input logic [ACT_W-1:0] act, input t_data val,
                            input logic typed, input t_dq_result typed_res);
        int gap;
        gap = 0;
        if (gaps_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.action     <= act;
        cmd_if.item_value <= val;
        row_typed         <= typed;
        row_result        <= typed_res;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_level() != 0) @(posedge i_clk);
    endtask

    // Receiver: stall in random bursts while gaps are on.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left   <= 0;
        end else if (stall_left != 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            res_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Predict on every command transfer, check on every result transfer.
    always @(posedge i_clk) begin
        t_dq_result want;
        if (i_rst_n && cmd_if.valid && cmd_if.ready) begin
            n_cmds++;
            deque_apply(cmd_if.action, cmd_if.item_value);
            // a typed row replaces the prediction with its own result
            if (row_typed) begin
                due_buf[(due_wr - 1) % DUE_SIZE] = row_result;
            end
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (due_level() == 0) begin
                $error("result with nothing owed: status %0d value %0d",
                       res_if.status, res_if.result_value);
                errors++;
            end else begin
                want = due_buf[due_rd % DUE_SIZE];
                due_rd++;
                n_checked++;
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    errors++;
                end
                if (res_if.result_value !== want.value) begin
                    $error("result_value: expected %0d, got %0d",
                           want.value, res_if.result_value);
                    errors++;
                end
                if (res_if.last_of_run !== want.last) begin
                    $error("last_of_run: expected %0b, got %0b",
                           want.last, res_if.last_of_run);
                    errors++;
                end
                if (res_if.occupancy !== want.occ) begin
                    $error("occupancy: expected %0d, got %0d", want.occ, res_if.occupancy);
                    errors++;
                end
            end
        end
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #500_000;
        $display("tb_double_ended_queue: errors");
        $finish;
    end

    initial begin
        logic [ACT_W-1:0] act;
        t_data            val;
        int               r;
        int               k;
        int               n;
        int               pick;
        bit               fill_mode;

        cmd_if.valid      = 1'b0;
        cmd_if.action     = ACT_PUSH_FRONT;
        cmd_if.item_value = V_ZERO;
        row_typed         = 1'b0;
        row_result        = '0;
        i_rst_n           = 1'b0;
        gaps_on           = 1'b1;
        fill_mode         = 1'b0;

        // Directed table: act, value, rnd, reps, typed, typed result.
        // Front pushes of the fill wrap the front index past zero.
        dir_rows = '{
            '{ACT_POP_FRONT,  V_ZERO, 1'b0, 5'd1,  1'b1, '{ST_POP_EMPTY,  V_ZERO, 1'b1, 5'd0}},
            '{ACT_POP_BACK,   V_ONES, 1'b0, 5'd1,  1'b1, '{ST_POP_EMPTY,  V_ZERO, 1'b1, 5'd0}},
            '{ACT_LIST,       V_MAX,  1'b0, 5'd1,  1'b1, '{ST_LIST_EMPTY, V_ZERO, 1'b1, 5'd0}},
            '{ACT_UNUSED_LO,  V_MIN,  1'b0, 5'd1,  1'b1, '{ST_DONE,       V_ZERO, 1'b1, 5'd0}},
            '{ACT_UNUSED_HI,  V_ONES, 1'b0, 5'd1,  1'b1, '{ST_DONE,       V_ZERO, 1'b1, 5'd0}},
            '{ACT_PUSH_FRONT, V_MAX,  1'b0, 5'd1,  1'b1, '{ST_DONE,       V_ZERO, 1'b1, 5'd1}},
            '{ACT_PUSH_BACK,  V_MIN,  1'b0, 5'd1,  1'b1, '{ST_DONE,       V_ZERO, 1'b1, 5'd2}},
            '{ACT_PUSH_FRONT, V_ZERO, 1'b0, 5'd1,  1'b1, '{ST_DONE,       V_ZERO, 1'b1, 5'd3}},
            '{ACT_PUSH_BACK,  V_ONES, 1'b0, 5'd1,  1'b1, '{ST_DONE,       V_ZERO, 1'b1, 5'd4}},
            '{ACT_LIST,       V_ZERO, 1'b0, 5'd1,  1'b0, '0},
            '{ACT_PUSH_BACK,  V_ZERO, 1'b1, 5'd6,  1'b0, '0},
            '{ACT_PUSH_FRONT, V_ZERO, 1'b1, 5'd6,  1'b0, '0},
            '{ACT_PUSH_FRONT, V_ZERO, 1'b1, 5'd1,  1'b1, '{ST_PUSH_FULL,  V_ZERO, 1'b1, 5'd16}},
            '{ACT_PUSH_BACK,  V_ZERO, 1'b1, 5'd1,  1'b1, '{ST_PUSH_FULL,  V_ZERO, 1'b1, 5'd16}},
            '{ACT_LIST,       V_ZERO, 1'b0, 5'd1,  1'b0, '0},
            '{ACT_POP_FRONT,  V_MIN,  1'b0, 5'd1,  1'b0, '0},
            '{ACT_POP_BACK,   V_MAX,  1'b0, 5'd1,  1'b0, '0},
            '{ACT_POP_FRONT,  V_ZERO, 1'b0, 5'd1,  1'b0, '0}
        };

        // Hold reset, then release it on an edge.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_ROWS; r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                val = dir_rows[r].rnd ? t_data'($urandom) : dir_rows[r].value;
                send_cmd(dir_rows[r].act, val, dir_rows[r].typed, dir_rows[r].res);
            end
        end

        // Let the directed results all come home before going random.
        drain_results();

        // Random part: alternate fill and drain stretches so the queue keeps
        // hitting both full and empty; sprinkle listings and unused codes.
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 32 == 0)
                fill_mode = !fill_mode;
            // quiet stretches, and none at all near the end
            gaps_on = (n < N_RANDOM - 30) && ((n / 24) % 3 != 2);
            if (n == N_RANDOM / 2)
                drain_results();

            pick = $urandom_range(0, 99);
            if (pick < 3)
                act = ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
            else if (pick < 11)
                act = ACT_LIST;
            else if (pick < (fill_mode ? 76 : 31))
                act = $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
            else
                act = $urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT;

            case ($urandom_range(0, 7))
                0:       val = V_MAX;
                1:       val = V_MIN;
                2:       val = V_ZERO;
                3:       val = V_ONES;
                default: val = t_data'($urandom);
            endcase
            send_cmd(act, val, 1'b0, '0);
        end

        // Wait out the owed results, then wait on for strays.
        drain_results();
        repeat (40) @(posedge i_clk);

        $display("Ran %0d commands and checked %0d results: %0d listings,",
                 n_cmds, n_checked, n_lists);
        $display("%0d pushes dropped on full, %0d pops on empty.", n_full, n_empty);
        if (errors == 0)
            $display("tb_double_ended_queue: clean");
        else
            $display("tb_double_ended_queue: errors");
        $finish;
    end

endmodule
